// File: src/mcspg_pkg.sv
// ----------------------------------------------------------------------------
// mcspg_pkg
// Shared types and constants of the multi-channel step pulse generator.
// ----------------------------------------------------------------------------
package mcspg_pkg;

   localparam int MOTOR_COUNT = 6;
   localparam int MOTOR_IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
   localparam int MOTOR_CNT_W = $clog2(MOTOR_COUNT + 1);
   localparam int OUT_W = 6;
   localparam int PAD_W = (MOTOR_COUNT > OUT_W) ? MOTOR_COUNT : OUT_W;

   localparam int PERIOD_NUMERATOR = 256000000;
   localparam int QUOT_W = $clog2(PERIOD_NUMERATOR + 1);
   localparam int QUOT_CNT_W = $clog2(QUOT_W);
   localparam logic [QUOT_W-1:0] PERIOD_NUM_BITS = QUOT_W'(PERIOD_NUMERATOR);

   localparam int PULSE_W = 10;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 10;
   localparam logic [PULSE_W-1:0] PULSE_WIDTH_RESET = PULSE_W'(5);

   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_SET_SPEED = 2'd1,
      OP_STOP_ONE  = 2'd2,
      OP_STOP_ALL  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SIGN_NONE = 2'd0,
      SIGN_POS  = 2'd1,
      SIGN_NEG  = 2'd3
   } sign_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PULSE_WIDTH = 1'd0,
      CSR_DIR_INVERT  = 1'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SWEEP,
      ST_REPLY
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [2:0]  motor;
      sign_type    sign;
      logic [31:0] interval;
      logic [31:0] now_us;
   } sweep_cmd_type;

   typedef struct packed {
      sign_type    sign;
      logic [31:0] interval;
      logic [31:0] last_step;
   } motor_entry_type;

endpackage

// File: src/multi_channel_step_pulse_generator.sv
// ----------------------------------------------------------------------------
// multi_channel_step_pulse_generator
// Step and direction generator for several stepper motors.
//
//   Channel  Direction  Handshake           Contents
//   req      in         req_valid/ready     op, motor, speed, now_us
//   rsp      out        rsp_valid/ready     step_mask, dir_levels, bad_index
//   csr      in         csr_we              pulse width, direction invert
//
// A transaction runs from acceptance to the next acceptance through the pass
// that reads and writes back one motor entry per cycle, then through the
// reply state. A set-speed transaction with a nonzero speed for a valid
// motor first passes through the restoring divider.
// Reset is synchronous and clears the motor memory through its valid bits.
// A new request is taken while an earlier response still waits on rsp_ready.
// ----------------------------------------------------------------------------
module multi_channel_step_pulse_generator import mcspg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_op,
   input  logic [2:0]             req_motor,
   input  logic signed [31:0]     req_speed,
   input  logic [31:0]            req_now_us,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [5:0]             rsp_step_mask,
   output logic [5:0]             rsp_dir_levels,
   output logic                   rsp_bad_index,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   state_type         state_ff, state_in;
   sweep_cmd_type     cmd_ff, cmd_in;
   logic              bad_ff, bad_in;
   logic              sweep_start_ff, sweep_start_in;
   logic              rsp_valid_ff;
   logic [5:0]        rsp_step_ff;
   logic [5:0]        rsp_dir_ff;
   logic              rsp_bad_ff;
   logic [PULSE_W-1:0] pulse_width_ff;
   logic [OUT_W-1:0]  dir_invert_ff;

   logic              accept;
   logic              div_start;
   logic              div_done;
   logic [QUOT_W-1:0] div_quot;
   logic              sweep_done;
   logic [OUT_W-1:0]  sweep_steps;
   logic [OUT_W-1:0]  sweep_levels;
   logic              rsp_load;
   op_type            req_op_e;
   logic [31:0]       speed_bits;
   logic [31:0]       speed_mag;
   logic              req_bad;
   logic              need_div;
   logic [PULSE_W:0]  floor_us;
   logic [31:0]       interval_sel;

   always_comb begin
      req_op_e = op_type'(req_op);
      speed_bits = req_speed;
      speed_mag = speed_bits[31] ? (~speed_bits + 32'd1) : speed_bits;
      req_bad = (req_op_e == OP_SET_SPEED || req_op_e == OP_STOP_ONE)
                && (32'(req_motor) >= 32'(MOTOR_COUNT));
      need_div = (req_op_e == OP_SET_SPEED) && !req_bad && (speed_bits != '0);
      floor_us = {pulse_width_ff, 1'b0};
      interval_sel = (32'(div_quot) < 32'(floor_us)) ? 32'(floor_us) : 32'(div_quot);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      bad_in = bad_ff;
      sweep_start_in = 1'b0;
      div_start = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in.op = req_op_e;
               cmd_in.motor = req_motor;
               cmd_in.now_us = req_now_us;
               cmd_in.interval = '0;
               cmd_in.sign = SIGN_NONE;
               if (need_div) begin
                  cmd_in.sign = speed_bits[31] ? SIGN_NEG : SIGN_POS;
               end
               bad_in = req_bad;
               if (need_div) begin
                  div_start = 1'b1;
                  state_in = ST_DIVIDE;
               end else begin
                  sweep_start_in = 1'b1;
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               cmd_in.interval = interval_sel;
               sweep_start_in = 1'b1;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (sweep_done) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sweep_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_start_ff <= sweep_start_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      bad_ff <= bad_in;
      if (rsp_load) begin
         rsp_step_ff <= sweep_steps;
         rsp_dir_ff <= sweep_levels;
         rsp_bad_ff <= bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_width_ff <= PULSE_WIDTH_RESET;
         dir_invert_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PULSE_WIDTH: pulse_width_ff <= csr_wdata[PULSE_W-1:0];
            CSR_DIR_INVERT:  dir_invert_ff <= csr_wdata[OUT_W-1:0];
            default: ;
         endcase
      end
   end

   mcspg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (speed_mag),
      .done     (div_done),
      .quotient (div_quot)
   );

   mcspg_sweep u_sweep (
      .clock      (clock),
      .reset      (reset),
      .start      (sweep_start_ff),
      .cmd        (cmd_ff),
      .dir_invert (dir_invert_ff),
      .done       (sweep_done),
      .step_mask  (sweep_steps),
      .dir_levels (sweep_levels)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_step_mask = rsp_step_ff;
   assign rsp_dir_levels = rsp_dir_ff;
   assign rsp_bad_index = rsp_bad_ff;

endmodule

// File: src/mcspg_divider.sv
// ----------------------------------------------------------------------------
// mcspg_divider
// Restoring divider that forms the constant period numerator divided by the
// speed magnitude, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcspg_divider import mcspg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [31:0]       divisor,
   output logic              done,
   output logic [QUOT_W-1:0] quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [QUOT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]           divisor_ff, divisor_in;
   logic [31:0]           rem_ff, rem_in;
   logic [QUOT_W-1:0]     quot_ff, quot_in;
   logic [32:0]           trial;
   logic [32:0]           diff;
   logic                  fits;

   always_comb begin
      trial = {rem_ff, PERIOD_NUM_BITS[cnt_ff]};
      diff = trial - {1'b0, divisor_ff};
      fits = (trial >= {1'b0, divisor_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      divisor_in = divisor_ff;
      rem_in = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = QUOT_CNT_W'(QUOT_W - 1);
         divisor_in = divisor;
         rem_in = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[31:0] : trial[31:0];
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - QUOT_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quotient = quot_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

// File: src/mcspg_sweep.sv
// ----------------------------------------------------------------------------
// mcspg_sweep
// Motor state memory and the read-modify-write pass over all motors that
// every transaction makes: stepping, speed updates, stops and direction
// refresh.
// ----------------------------------------------------------------------------
module mcspg_sweep import mcspg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  sweep_cmd_type    cmd,
   input  logic [OUT_W-1:0] dir_invert,
   output logic             done,
   output logic [OUT_W-1:0] step_mask,
   output logic [OUT_W-1:0] dir_levels
);

   motor_entry_type mem [MOTOR_COUNT];

   logic [MOTOR_COUNT-1:0] written_ff, written_in;
   logic                   rd_active_ff, rd_active_in;
   logic [MOTOR_CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic                   wr_active_ff;
   logic                   done_ff, done_in;
   logic [MOTOR_COUNT-1:0] step_ff, step_in;
   logic [MOTOR_COUNT-1:0] level_ff, level_in;
   logic [MOTOR_IDX_W-1:0] wr_idx_ff;
   motor_entry_type        rd_data_ff;
   logic                   rd_written_ff;

   logic [MOTOR_IDX_W-1:0] rd_idx;
   logic                   last_rd;
   motor_entry_type        cur;
   motor_entry_type        upd;
   logic                   hit;
   logic                   due;
   logic [31:0]            elapsed;
   logic [PAD_W-1:0]       inv_pad;
   logic [PAD_W-1:0]       step_pad;
   logic [PAD_W-1:0]       level_pad;
   logic                   inv_bit;

   assign rd_idx = rd_cnt_ff[MOTOR_IDX_W-1:0];
   assign last_rd = (rd_cnt_ff == MOTOR_CNT_W'(MOTOR_COUNT - 1));

   always_comb begin
      rd_active_in = rd_active_ff;
      rd_cnt_in = rd_cnt_ff;
      if (start) begin
         rd_active_in = 1'b1;
         rd_cnt_in = '0;
      end else if (rd_active_ff) begin
         if (last_rd) begin
            rd_active_in = 1'b0;
            rd_cnt_in = '0;
         end else begin
            rd_cnt_in = rd_cnt_ff + MOTOR_CNT_W'(1);
         end
      end
      done_in = wr_active_ff && !rd_active_ff;
   end

   always_comb begin
      cur = rd_written_ff ? rd_data_ff : '0;
      upd = cur;
      hit = (32'(cmd.motor) == 32'(wr_idx_ff));
      elapsed = cmd.now_us - cur.last_step;
      due = 1'b0;
      case (cmd.op)
         OP_TICK: begin
            if (cur.interval != '0 && cur.sign != SIGN_NONE && elapsed >= cur.interval) begin
               due = 1'b1;
               upd.last_step = cmd.now_us;
            end
         end
         OP_SET_SPEED: begin
            if (hit) begin
               upd.sign = cmd.sign;
               upd.interval = cmd.interval;
            end
         end
         OP_STOP_ONE: begin
            if (hit) begin
               upd.sign = SIGN_NONE;
               upd.interval = '0;
            end
         end
         OP_STOP_ALL: begin
            upd.sign = SIGN_NONE;
            upd.interval = '0;
         end
         default: ;
      endcase
   end

   always_comb begin
      inv_pad = PAD_W'(dir_invert);
      inv_bit = inv_pad[wr_idx_ff];
      written_in = written_ff;
      step_in = start ? '0 : step_ff;
      level_in = level_ff;
      if (wr_active_ff) begin
         written_in[wr_idx_ff] = 1'b1;
         if (due) begin
            step_in[wr_idx_ff] = 1'b1;
         end
         if (upd.sign == SIGN_POS) begin
            level_in[wr_idx_ff] = ~inv_bit;
         end else if (upd.sign == SIGN_NEG) begin
            level_in[wr_idx_ff] = inv_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         rd_active_ff <= 1'b0;
         rd_cnt_ff <= '0;
         wr_active_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         level_ff <= '0;
      end else begin
         written_ff <= written_in;
         rd_active_ff <= rd_active_in;
         rd_cnt_ff <= rd_cnt_in;
         wr_active_ff <= rd_active_ff;
         done_ff <= done_in;
         step_ff <= step_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_idx_ff <= rd_idx;
      rd_data_ff <= mem[rd_idx];
      rd_written_ff <= written_ff[rd_idx];
      if (wr_active_ff) begin
         mem[wr_idx_ff] <= upd;
      end
   end

   assign step_pad = PAD_W'(step_ff);
   assign level_pad = PAD_W'(level_ff);
   assign step_mask = step_pad[OUT_W-1:0];
   assign dir_levels = level_pad[OUT_W-1:0];
   assign done = done_ff;

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      wr_active_ff && rd_active_ff |-> wr_idx_ff != rd_idx)
      else $error("read and write hit the same motor entry");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !rd_active_ff && !wr_active_ff)
      else $error("pass started while another was running");

   a_steps_on_tick: assert property (@(posedge clock) disable iff (reset)
      done_ff && cmd.op != OP_TICK |-> step_ff == '0)
      else $error("step issued by a transaction that is not a tick");

endmodule

// File: test/tb_multi_channel_step_pulse_generator.sv
// ----------------------------------------------------------------------------
// tb_multi_channel_step_pulse_generator
// Self-checking testbench for the multi-channel step pulse generator.
//
// A queue of commands is filled by the sequencer and driven one transaction
// at a time. Each accepted command is run through a behavioural model of the
// motor table. The model gives the step mask, the direction levels and the
// index flag that the response must carry. Responses are compared in order.
// Both handshakes stall in random bursts except in the last phase. Between
// phases the pipeline drains and the configuration registers are rewritten.
// ----------------------------------------------------------------------------
module tb_multi_channel_step_pulse_generator;
   import mcspg_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 10;
   localparam int SETTLE_CYCLES  = 60;
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int REPORT_LIMIT   = 10;
   localparam int PHASE_ITEMS    = 390;

   typedef struct packed {
      op_type      op;
      logic [2:0]  motor;
      logic [31:0] speed;
      logic [31:0] now_us;
   } step_command_type;

   typedef struct packed {
      logic [5:0] step_mask;
      logic [5:0] dir_levels;
      logic       bad_index;
   } step_outputs_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_op = OP_TICK;
   logic [2:0]             req_motor = '0;
   logic [31:0]            req_speed = '0;
   logic [31:0]            req_now_us = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [5:0]             rsp_step_mask;
   logic [5:0]             rsp_dir_levels;
   logic                   rsp_bad_index;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_PULSE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   step_command_type pending_commands[$];
   step_outputs_type expected_outputs[$];
   step_command_type driven_command;

   sign_type    motor_sign      [MOTOR_COUNT];
   logic [31:0] motor_interval  [MOTOR_COUNT];
   logic [31:0] motor_last_step [MOTOR_COUNT];
   logic        motor_dir       [MOTOR_COUNT];
   logic [9:0]  pulse_width     = PULSE_WIDTH_RESET;
   logic [5:0]  dir_invert_bits = '0;

   logic [31:0] stim_clock       = '0;
   logic        idle_enabled     = 1'b1;
   int unsigned mismatch_count   = 0;
   int unsigned sender_gap       = 0;
   int unsigned sender_calm      = 0;
   int unsigned receiver_stall   = 0;
   int unsigned receiver_calm    = 0;

   multi_channel_step_pulse_generator i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_motor      (req_motor),
      .req_speed      (req_speed),
      .req_now_us     (req_now_us),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_step_mask  (rsp_step_mask),
      .rsp_dir_levels (rsp_dir_levels),
      .rsp_bad_index  (rsp_bad_index),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #(CLOCK_PERIOD / 2);
      clock = 1'b1;
      #(CLOCK_PERIOD / 2);
   end

   function automatic logic [31:0] step_interval_for(input logic [31:0] speed,
                                                     input logic [9:0]  width_us);
      logic [63:0] magnitude;
      logic [63:0] quotient;
      logic [63:0] floor_us;
      magnitude = speed[31] ? {32'd0, ~speed + 32'd1} : {32'd0, speed};
      quotient  = 64'(PERIOD_NUMERATOR) / magnitude;
      floor_us  = 64'(width_us) * 64'd2;
      if (quotient < floor_us) begin
         quotient = floor_us;
      end
      return quotient[31:0];
   endfunction

   task automatic predict_step_outputs(input step_command_type cmd,
                                       output step_outputs_type res);
      logic [31:0] elapsed;
      res = '0;
      case (cmd.op)
         OP_TICK: begin
            for (int m = 0; m < MOTOR_COUNT; m++) begin
               if (motor_interval[m] != 0 && motor_sign[m] != SIGN_NONE) begin
                  elapsed = cmd.now_us - motor_last_step[m];
                  if (elapsed >= motor_interval[m]) begin
                     motor_last_step[m] = cmd.now_us;
                     res.step_mask[m]   = 1'b1;
                  end
               end
            end
         end
         OP_SET_SPEED, OP_STOP_ONE: begin
            if (cmd.motor >= MOTOR_COUNT) begin
               res.bad_index = 1'b1;
            end else if (cmd.op == OP_STOP_ONE || cmd.speed == 0) begin
               motor_sign[cmd.motor]     = SIGN_NONE;
               motor_interval[cmd.motor] = '0;
            end else begin
               motor_sign[cmd.motor]     = cmd.speed[31] ? SIGN_NEG : SIGN_POS;
               motor_interval[cmd.motor] = step_interval_for(cmd.speed, pulse_width);
            end
         end
         default: begin
            for (int m = 0; m < MOTOR_COUNT; m++) begin
               motor_sign[m]     = SIGN_NONE;
               motor_interval[m] = '0;
            end
         end
      endcase
      for (int m = 0; m < MOTOR_COUNT; m++) begin
         if (motor_sign[m] == SIGN_POS) begin
            motor_dir[m] = ~dir_invert_bits[m];
         end else if (motor_sign[m] == SIGN_NEG) begin
            motor_dir[m] = dir_invert_bits[m];
         end
         res.dir_levels[m] = motor_dir[m];
      end
   endtask

   task automatic note_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, field, want, got);
      end
   endtask

   // The driver holds each transaction until it is accepted and predicts its
   // response at the accepting edge.
   always @(posedge clock) begin : driver
      step_outputs_type predicted;
      logic             accepted;
      accepted = req_valid && req_ready;
      if (!reset && accepted) begin
         predict_step_outputs(driven_command, predicted);
         expected_outputs.push_back(predicted);
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || accepted) begin
         if (sender_gap > 0) begin
            sender_gap--;
            req_valid <= 1'b0;
         end else if (pending_commands.size() == 0) begin
            req_valid <= 1'b0;
         end else if (idle_enabled && sender_calm == 0 && $urandom_range(0, 3) == 0) begin
            sender_gap  = $urandom_range(0, 17);
            sender_calm = $urandom_range(0, 40);
            req_valid <= 1'b0;
         end else begin
            if (sender_calm > 0) begin
               sender_calm--;
            end
            driven_command = pending_commands.pop_front();
            req_valid  <= 1'b1;
            req_op     <= driven_command.op;
            req_motor  <= driven_command.motor;
            req_speed  <= driven_command.speed;
            req_now_us <= driven_command.now_us;
         end
      end
   end

   always @(posedge clock) begin : monitor
      step_outputs_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outputs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: response with no transaction outstanding", $realtime);
            end
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_step_mask !== want.step_mask) begin
               note_mismatch("step_mask", 32'(want.step_mask), 32'(rsp_step_mask));
            end
            if (rsp_dir_levels !== want.dir_levels) begin
               note_mismatch("dir_levels", 32'(want.dir_levels), 32'(rsp_dir_levels));
            end
            if (rsp_bad_index !== want.bad_index) begin
               note_mismatch("bad_index", 32'(want.bad_index), 32'(rsp_bad_index));
            end
         end
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (receiver_stall > 0) begin
         receiver_stall--;
         rsp_ready <= 1'b0;
      end else if (idle_enabled && receiver_calm == 0 && $urandom_range(0, 5) == 0) begin
         receiver_stall = $urandom_range(0, 17);
         receiver_calm  = $urandom_range(0, 60);
         rsp_ready <= 1'b0;
      end else begin
         if (receiver_calm > 0) begin
            receiver_calm--;
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic push_command(input op_type op, input logic [2:0] motor,
                               input logic [31:0] speed, input logic [31:0] now_us);
      step_command_type cmd;
      cmd.op     = op;
      cmd.motor  = motor;
      cmd.speed  = speed;
      cmd.now_us = now_us;
      pending_commands.push_back(cmd);
   endtask

   task automatic queue_random_commands(input int unsigned count);
      step_command_type cmd;
      int unsigned      pick;
      logic [31:0]      magnitude;
      for (int unsigned n = 0; n < count; n++) begin
         pick       = $urandom_range(0, 99);
         cmd.motor  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                  : 3'($urandom_range(0, 5));
         cmd.speed  = $urandom();
         cmd.now_us = $urandom();
         if (pick < 65) begin
            cmd.op = OP_TICK;
            case ($urandom_range(0, 19))
               0:       stim_clock = $urandom();
               1:       stim_clock = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000));
               2, 3:    stim_clock = stim_clock + 32'($urandom_range(0, 20000));
               default: stim_clock = stim_clock + 32'($urandom_range(0, 400));
            endcase
            cmd.now_us = stim_clock;
         end else if (pick < 85) begin
            cmd.op = OP_SET_SPEED;
            case ($urandom_range(0, 9))
               0: ;
               1: cmd.speed = '0;
               2: begin
                  magnitude = $urandom_range(1, 255);
                  cmd.speed = $urandom_range(0, 1) ? ~magnitude + 32'd1 : magnitude;
               end
               default: begin
                  magnitude = 32'(PERIOD_NUMERATOR) / 32'($urandom_range(2, 4000));
                  cmd.speed = $urandom_range(0, 1) ? ~magnitude + 32'd1 : magnitude;
               end
            endcase
         end else if (pick < 95) begin
            cmd.op = OP_STOP_ONE;
         end else begin
            cmd.op = OP_STOP_ALL;
         end
         pending_commands.push_back(cmd);
      end
   endtask

   task automatic wait_for_drain();
      while (pending_commands.size() != 0 || expected_outputs.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [9:0] width_us, input logic [5:0] invert);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_PULSE_WIDTH;
      csr_wdata <= width_us;
      @(posedge clock);
      csr_index <= CSR_DIR_INVERT;
      csr_wdata <= {4'($urandom()), invert};
      @(posedge clock);
      csr_we <= 1'b0;
      pulse_width     = width_us;
      dir_invert_bits = invert;
      @(negedge clock);
   endtask

   initial begin : sequencer
      for (int m = 0; m < MOTOR_COUNT; m++) begin
         motor_sign[m]      = SIGN_NONE;
         motor_interval[m]  = '0;
         motor_last_step[m] = '0;
         motor_dir[m]       = 1'b0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_command(OP_TICK,      3'd0, 32'h0000_0000, 32'h0000_0000);
      push_command(OP_SET_SPEED, 3'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      push_command(OP_SET_SPEED, 3'd1, 32'h8000_0000, 32'h0000_0000);
      push_command(OP_SET_SPEED, 3'd2, 32'h0000_0001, 32'h0000_0000);
      push_command(OP_SET_SPEED, 3'd3, 32'hFFFF_FFFF, 32'h0000_0000);
      push_command(OP_SET_SPEED, 3'd4, 32'd25600,     32'h0000_0000);
      push_command(OP_SET_SPEED, 3'd5, 32'(-2560000), 32'h0000_0000);
      push_command(OP_SET_SPEED, 3'd6, 32'd100,       32'h0000_0000);
      push_command(OP_STOP_ONE,  3'd7, 32'h0000_0000, 32'h0000_0000);
      push_command(OP_TICK,      3'd7, 32'hFFFF_FFFF, 32'd5);
      push_command(OP_TICK,      3'd0, 32'h0000_0000, 32'd10);
      push_command(OP_TICK,      3'd6, 32'h0000_0000, 32'd100);
      push_command(OP_SET_SPEED, 3'd0, 32'h0000_0000, 32'h0000_0000);
      push_command(OP_STOP_ONE,  3'd1, 32'h0000_0000, 32'h0000_0000);
      push_command(OP_TICK,      3'd0, 32'h0000_0000, 32'hFFFF_FFF0);
      push_command(OP_TICK,      3'd0, 32'h0000_0000, 32'h0000_0010);
      push_command(OP_TICK,      3'd0, 32'h0000_0000, 32'h0000_0060);
      push_command(OP_SET_SPEED, 3'd4, 32'(-256000000), 32'h0000_0000);
      push_command(OP_STOP_ALL,  3'd7, 32'h0000_0000, 32'h0000_0000);
      push_command(OP_TICK,      3'd0, 32'h0000_0000, 32'hFFFF_FFFF);
      push_command(OP_SET_SPEED, 3'd5, 32'h0000_0001, 32'hFFFF_FFFF);
      wait_for_drain();

      // With no minimum pulse width a very high speed leaves the interval at
      // zero, so the motor must never step.
      apply_settings(10'd0, 6'h3F);
      push_command(OP_SET_SPEED, 3'd0, 32'h7FFF_FFFF, 32'h0000_0000);
      push_command(OP_SET_SPEED, 3'd1, 32'h8000_0000, 32'h0000_0000);
      push_command(OP_TICK,      3'd0, 32'h0000_0000, 32'h8000_0000);
      push_command(OP_TICK,      3'd0, 32'h0000_0000, 32'h8000_0001);
      stim_clock = $urandom();
      queue_random_commands(PHASE_ITEMS);
      wait_for_drain();

      apply_settings(10'd1000, 6'($urandom()));
      stim_clock = 32'hFFFF_0000;
      queue_random_commands(PHASE_ITEMS);
      wait_for_drain();

      apply_settings(10'd1, 6'h2A);
      stim_clock = $urandom();
      queue_random_commands(PHASE_ITEMS);
      wait_for_drain();

      apply_settings(10'($urandom_range(1, 1000)), 6'($urandom()));
      queue_random_commands(PHASE_ITEMS);
      wait_for_drain();

      apply_settings(10'd5, 6'h15);
      idle_enabled = 1'b0;
      queue_random_commands(PHASE_ITEMS);
      wait_for_drain();

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("Regression FAIL");
      $finish;
   end

endmodule
